@@ src/mexp_pkg.sv @@
// Package for the modular exponentiation block.
// Holds the port widths, register indexes and reset values used by the top level
// and by its checker. It depends on nothing else.
`default_nettype none

package mexp_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int DATA_W        = 32;
  localparam int EXP_W         = 32;
  localparam int EXP_IDX_W     = $clog2(EXP_W);
  localparam int IDX_W         = 2;

  localparam logic [IDX_W-1:0] REG_PRIVATE_EXPONENT = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_MODULUS      = 2'd1;

  localparam logic [DATA_W-1:0] EXPONENT_RESET = 32'd1;
  localparam logic [DATA_W-1:0] MODULUS_RESET  = 32'd2;

endpackage

`default_nettype wire

@@ src/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: message = ciphertext^d mod n.
// Uses mexp_pkg for widths, register indexes and reset values.
//
// Usage. The key is held in two registers written through the configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 is the private
// exponent d, index 1 the modulus n. cfg_ready is always high, so every write
// is a transfer; an index beyond these two is ignored. Write the key only while
// busy is low. A ciphertext is taken at a clock edge with start high and busy
// low. The result appears on message, and done marks it for exactly one cycle;
// busy falls in the cycle after that. The receiver cannot stall the block.
// Operation. One modular multiplication or the initial reduction of the
// ciphertext works through WIDTH bits, one bit per cycle through the shared
// double-add-reduce unit. From the transfer of start to done the block
// performs one reduction, 32 squarings and one multiplication for every set
// bit of d. A modulus below 2 gives 0 in the cycle right after the transfer.
// The next start transfer can come at the edge that ends the cycle after
// done; no new ciphertext is taken while busy is high.
// Reset. rst loads d = 1 and n = 2 and returns the sequencer to idle.
`default_nettype none

module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::DEFAULT_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mexp_pkg::DATA_W-1:0]    ciphertext,
  output logic                                done,
  output logic [mexp_pkg::DATA_W-1:0]         message,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mexp_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [mexp_pkg::DATA_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);
  localparam logic [mexp_pkg::EXP_IDX_W-1:0] LAST_EBIT =
    mexp_pkg::EXP_IDX_W'(mexp_pkg::EXP_W - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REDUCE = 4'b0010,
    S_MUL    = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                         state;
  logic [mexp_pkg::DATA_W-1:0]    private_exponent;
  logic [mexp_pkg::DATA_W-1:0]    key_modulus;

  logic [WIDTH-1:0]               acc;
  logic [WIDTH-1:0]               result;
  logic [WIDTH-1:0]               base;
  logic [WIDTH-1:0]               y;
  logic [mexp_pkg::EXP_W-1:0]     expo;
  logic [CNT_W-1:0]               cnt;
  logic [mexp_pkg::EXP_IDX_W-1:0] ecnt;
  logic                           phase_mul;

  logic [WIDTH-1:0]               modulus;
  logic [WIDTH+1:0]               addend;
  logic [WIDTH+1:0]               sum;
  logic [WIDTH+1:0]               mod_x1;
  logic [WIDTH+1:0]               mod_x2;
  logic [WIDTH-1:0]               acc_next;

  assign modulus   = WIDTH'(key_modulus);
  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign message   = mexp_pkg::DATA_W'(result);

  // Shared unit: (2 * acc + addend) mod n, where acc < n and addend < n.
  always_comb begin
    if (state == S_REDUCE) begin
      addend = (WIDTH+2)'(y[WIDTH-1]);
    end else if (y[WIDTH-1]) begin
      addend = (WIDTH+2)'(result);
    end else begin
      addend = '0;
    end
    sum    = {1'b0, acc, 1'b0} + addend;
    mod_x1 = (WIDTH+2)'(modulus);
    mod_x2 = {1'b0, modulus, 1'b0};
    if (sum >= mod_x2) begin
      acc_next = WIDTH'(sum - mod_x2);
    end else if (sum >= mod_x1) begin
      acc_next = WIDTH'(sum - mod_x1);
    end else begin
      acc_next = WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      private_exponent <= mexp_pkg::EXPONENT_RESET;
      key_modulus      <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mexp_pkg::REG_PRIVATE_EXPONENT: private_exponent <= cfg_data;
        mexp_pkg::REG_KEY_MODULUS:      key_modulus      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (modulus < WIDTH'(2)) begin
              result <= '0;
              state  <= S_DONE;
            end else begin
              acc       <= '0;
              y         <= WIDTH'(ciphertext);
              cnt       <= '0;
              ecnt      <= '0;
              expo      <= private_exponent;
              result    <= WIDTH'(1);
              phase_mul <= 1'b0;
              state     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          acc <= acc_next;
          y   <= y << 1;
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            base  <= acc_next;
            acc   <= '0;
            y     <= result;
            cnt   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc <= acc_next;
          y   <= y << 1;
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            result <= acc_next;
            acc    <= '0;
            cnt    <= '0;
            if (!phase_mul && expo[mexp_pkg::EXP_W-1]) begin
              phase_mul <= 1'b1;
              y         <= base;
            end else if (ecnt == LAST_EBIT) begin
              state <= S_DONE;
            end else begin
              phase_mul <= 1'b0;
              y         <= acc_next;
              expo      <= expo << 1;
              ecnt      <= ecnt + 1'b1;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/mexp_checker.sv @@
// Port-level checker for the modular exponentiation block, bound to its top level.
// Uses mexp_pkg for the port widths.
`default_nettype none

module mexp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [mexp_pkg::DATA_W-1:0] message
);

  // A result is shown for one cycle only.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done was held for more than one cycle");

  // A delivered result carries a known value.
  assert property (@(posedge clk) disable iff (rst) done |-> !$isunknown(message))
    else $error("message was unknown while done was high");

  // A transfer on start makes the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy did not rise after a start transfer");

  // Once the result has been delivered the block is free again.
  assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy stayed high after the result");

  // The block only goes idle by delivering a result.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> $past(done))
    else $error("busy fell without a result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .message (message)
);

`default_nettype wire
